// ----- hdl/hex_token_line_stats_macros.svh -----
// ----------------------------------------------------------------------------
// hex_token_line_stats_macros.svh
// Assertion macros shared by the hex token line statistics block.
// ----------------------------------------------------------------------------
`ifndef HEX_TOKEN_LINE_STATS_MACROS_SVH
`define HEX_TOKEN_LINE_STATS_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must never hold while out of reset
`define HTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HTS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define HTS_ASSERT_NEVER(lbl, cond, msg)
`define HTS_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// hts_pkg
// Types, constants and helpers for the hex token line statistics block.
// ----------------------------------------------------------------------------
package hts_pkg;

  // default sizing
  localparam int VALUE_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // fixed result field widths
  localparam int CNT_OUT_W = 16;
  localparam int MAX_OUT_W = 32;
  localparam int AVG_OUT_W = 39;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // input word: one text byte
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } in_word_t;

  // output word: one finished line
  typedef struct packed {
    logic                 no_numbers;
    logic [CNT_OUT_W-1:0] number_count;
    logic [MAX_OUT_W-1:0] max_value;
    logic [AVG_OUT_W-1:0] average_x100;
  } out_word_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      d = ch - CH_0;
      return {1'b1, d[3:0]};
    end
    if (ch >= CH_LA && ch <= CH_LF_HEX) begin
      d = ch - CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (ch >= CH_UA && ch <= CH_UF) begin
      d = ch - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ----- hdl/hts_front.sv -----
// ----------------------------------------------------------------------------
// hts_front
// Tokeniser: takes one byte a cycle while the queue has room, builds words and
// line totals; a newline queues a line record, end of stream a non-empty one.
// ----------------------------------------------------------------------------
module hts_front #(
  parameter int VALUE_BITS = hts_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = hts_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             char_valid,
  output logic                             char_stall,
  input  hts_pkg::in_word_t                char_word,
  input  logic                             q_full,
  output logic                             push,
  output logic [COUNT_BITS-1:0]            push_count,
  output logic [VALUE_BITS+COUNT_BITS-1:0] push_sum,
  output logic [VALUE_BITS-1:0]            push_max
);

  localparam int SUM_W = VALUE_BITS + COUNT_BITS;

  logic [VALUE_BITS-1:0] word_value;
  logic                  word_still_valid;
  logic                  word_has_digits;
  logic [COUNT_BITS-1:0] line_number_count;
  logic [SUM_W-1:0]      line_value_sum;
  logic [VALUE_BITS-1:0] line_max_value;

  logic                  accept;
  logic                  eos;
  logic [7:0]            ch;
  logic                  is_blank;
  logic                  is_lf;
  logic [4:0]            digit;
  logic                  word_ok;
  logic [COUNT_BITS-1:0] count_c;
  logic [SUM_W-1:0]      sum_c;
  logic [VALUE_BITS-1:0] max_c;

  assign char_stall = q_full;

  // classify the byte and work out the line totals once the word closes
  always_comb begin
    accept   = char_valid & ~char_stall;
    eos      = char_word.end_of_stream;
    ch       = char_word.char_code;
    is_blank = (ch == hts_pkg::CH_SPACE) || (ch >= hts_pkg::CH_TAB && ch <= hts_pkg::CH_CR);
    is_lf    = (ch == hts_pkg::CH_LF);
    digit    = hts_pkg::hex_nibble(ch);
    word_ok  = word_has_digits & word_still_valid;
    count_c  = line_number_count;
    sum_c    = line_value_sum;
    if (word_ok && !(&line_number_count)) begin
      count_c = line_number_count + COUNT_BITS'(1);
      sum_c   = line_value_sum + SUM_W'(word_value);
    end
    max_c = (word_ok && word_value > line_max_value) ? word_value : line_max_value;
    push  = accept & ((~eos & is_lf) | (eos & (count_c != '0)));
  end

  assign push_count = count_c;
  assign push_sum   = sum_c;
  assign push_max   = max_c;

  // word and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_value        <= '0;
      word_still_valid  <= 1'b1;
      word_has_digits   <= 1'b0;
      line_number_count <= '0;
      line_value_sum    <= '0;
      line_max_value    <= '0;
    end else if (accept) begin
      if (eos || is_blank) begin
        word_value       <= '0;
        word_still_valid <= 1'b1;
        word_has_digits  <= 1'b0;
        if (eos || is_lf) begin
          line_number_count <= '0;
          line_value_sum    <= '0;
          line_max_value    <= '0;
        end else begin
          line_number_count <= count_c;
          line_value_sum    <= sum_c;
          line_max_value    <= max_c;
        end
      end else if (digit[4]) begin
        if (word_still_valid) begin
          word_value      <= {word_value[VALUE_BITS-5:0], digit[3:0]};
          word_has_digits <= 1'b1;
        end
      end else begin
        word_still_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/hts_fifo.sv -----
// ----------------------------------------------------------------------------
// hts_fifo
// Small register queue carrying line records from front to back end.
// ----------------------------------------------------------------------------
module hts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output hts_pkg::fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign stat.full  = (fill == CNT_W'(DEPTH));
  assign stat.empty = (fill == '0);
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/hts_back.sv -----
// ----------------------------------------------------------------------------
// hts_back
// Line result unit: takes a line record, works out the rounded average
// times 100 with a bit-per-cycle restoring divider, and holds the result.
// ----------------------------------------------------------------------------
module hts_back #(
  parameter int VALUE_BITS = hts_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = hts_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  output logic                             pop,
  input  logic [COUNT_BITS-1:0]            pop_count,
  input  logic [VALUE_BITS+COUNT_BITS-1:0] pop_sum,
  input  logic [VALUE_BITS-1:0]            pop_max,
  output logic                             line_valid,
  input  logic                             line_stall,
  output hts_pkg::out_word_t               line_word
);

  localparam int SUM_W     = VALUE_BITS + COUNT_BITS;
  localparam int NUM_W     = SUM_W + 9;
  localparam int DEN_W     = COUNT_BITS + 1;
  localparam int STEP_W    = $clog2(NUM_W + 1);
  localparam int CNT_OUT_W = hts_pkg::CNT_OUT_W;
  localparam int MAX_OUT_W = hts_pkg::MAX_OUT_W;
  localparam int AVG_OUT_W = hts_pkg::AVG_OUT_W;

  hts_pkg::bk_state_t state;
  hts_pkg::bk_state_t state_next;

  logic [NUM_W-1:0]      quo;
  logic [DEN_W-1:0]      rem;
  logic [DEN_W-1:0]      den;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS-1:0] res_count;
  logic [VALUE_BITS-1:0] res_max;
  logic                  res_empty;

  logic [NUM_W-1:0]      sum_ext;
  logic [NUM_W-1:0]      num;
  logic [DEN_W:0]        trial;
  logic [DEN_W:0]        diff;
  logic                  ge;
  logic                  last_step;

  // numerator 200*sum + n, denominator 2*n
  always_comb begin
    sum_ext = NUM_W'(pop_sum);
    num     = (sum_ext << 7) + (sum_ext << 6) + (sum_ext << 3) + NUM_W'(pop_count);
  end

  // one restoring division step
  always_comb begin
    trial     = {rem, quo[NUM_W-1]};
    diff      = trial - {1'b0, den};
    ge        = (trial >= {1'b0, den});
    last_step = (step == STEP_W'(NUM_W - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hts_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_next = (pop_count == '0) ? hts_pkg::BK_OUT : hts_pkg::BK_DIV;
        end
      end
      hts_pkg::BK_DIV: begin
        if (last_step) begin
          state_next = hts_pkg::BK_OUT;
        end
      end
      hts_pkg::BK_OUT: begin
        if (!line_stall) begin
          state_next = hts_pkg::BK_IDLE;
        end
      end
      default: state_next = hts_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop                    = (state == hts_pkg::BK_IDLE) && !q_empty;
    line_valid             = (state == hts_pkg::BK_OUT);
    line_word.no_numbers   = res_empty;
    line_word.number_count = CNT_OUT_W'(res_count);
    line_word.max_value    = MAX_OUT_W'(res_max);
    line_word.average_x100 = AVG_OUT_W'(quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hts_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider datapath and result hold
  always_ff @(posedge clk) begin
    if (pop) begin
      quo       <= (pop_count == '0) ? '0 : num;
      rem       <= '0;
      den       <= {pop_count, 1'b0};
      step      <= '0;
      res_count <= pop_count;
      res_max   <= (pop_count == '0) ? '0 : pop_max;
      res_empty <= (pop_count == '0);
    end else if (state == hts_pkg::BK_DIV) begin
      quo  <= {quo[NUM_W-2:0], ge};
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      step <= step + STEP_W'(1);
    end
  end

endmodule

// ----- hdl/hex_token_line_stats.sv -----
// ----------------------------------------------------------------------------
// hex_token_line_stats
// Hex word tokeniser with per-line count, maximum and rounded average.
// ----------------------------------------------------------------------------
// Usage:
//   char channel (char_valid / char_stall / char_word) carries one text byte
//   a word, or an end-of-stream mark. line channel (line_valid / line_stall /
//   line_word) carries one word per finished line.
//   A byte is taken every cycle while the line queue has room; the front end
//   has no other stall.
//   Each line record passes through the back end states idle, divide and
//   output, the divide state run by the one-bit-per-cycle restoring
//   divider; an empty line skips the divide state. The back end takes a
//   new record only once the last result has gone out, so a result comes
//   later if earlier lines are still queued. Bytes run at one a cycle as long
//   as the back end keeps up with the lines; runs of short lines fill the
//   QUEUE_DEPTH-entry queue and then char_stall rises.
//   When line_stall is high the result word is held and the back end waits;
//   the front end keeps taking bytes until the queue is full.
//   Synchronous reset clears word, line, queue and back end; no result is
//   pending after reset.
// ----------------------------------------------------------------------------
`include "hex_token_line_stats_macros.svh"

module hex_token_line_stats #(
  parameter int VALUE_BITS  = hts_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS  = hts_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = hts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  hts_pkg::in_word_t  char_word,
  output logic               line_valid,
  input  logic               line_stall,
  output hts_pkg::out_word_t line_word
);

  localparam int SUM_W = VALUE_BITS + COUNT_BITS;
  localparam int REC_W = COUNT_BITS + SUM_W + VALUE_BITS;

  hts_pkg::fifo_stat_t   q_stat;
  logic                  push;
  logic                  pop;
  logic [COUNT_BITS-1:0] push_count;
  logic [SUM_W-1:0]      push_sum;
  logic [VALUE_BITS-1:0] push_max;
  logic [REC_W-1:0]      push_rec;
  logic [REC_W-1:0]      pop_rec;
  logic [COUNT_BITS-1:0] pop_count;
  logic [SUM_W-1:0]      pop_sum;
  logic [VALUE_BITS-1:0] pop_max;

  // tokeniser
  hts_front #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_word (char_word),
    .q_full    (q_stat.full),
    .push      (push),
    .push_count(push_count),
    .push_sum  (push_sum),
    .push_max  (push_max)
  );

  // line record queue
  assign push_rec = {push_count, push_sum, push_max};
  assign {pop_count, pop_sum, pop_max} = pop_rec;

  hts_fifo #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_rec),
    .pop      (pop),
    .pop_data (pop_rec),
    .stat     (q_stat)
  );

  // average and result
  hts_back #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .pop_count (pop_count),
    .pop_sum   (pop_sum),
    .pop_max   (pop_max),
    .line_valid(line_valid),
    .line_stall(line_stall),
    .line_word (line_word)
  );

  // checks
  `HTS_ASSERT_NEVER(a_queue_overflow, push && q_stat.full, "line record pushed into full queue")
  `HTS_ASSERT_NEVER(a_queue_underflow, pop && q_stat.empty, "line record popped from empty queue")
  `HTS_ASSERT_IMPLY(a_empty_line_zero, line_valid && line_word.no_numbers, line_word.number_count == 16'd0 && line_word.max_value == 32'd0 && line_word.average_x100 == 39'd0, "empty line result has non-zero fields")

endmodule

// ----- tb/hex_token_line_stats_test.sv -----
// ----------------------------------------------------------------------------
// hex_token_line_stats_test
// Self-checking bench for the hex word tokeniser with per-line statistics.
// Bytes are sent through the char channel with random gaps, line words are
// taken with random stalls, and every line word is compared field by field
// with a line predictor kept in the bench or a word typed into the table. A
// short table of directed bytes comes first, then a burst of short lines
// against a held-off receiver, then random text that is mostly well-formed
// lines of hex words mixed with noise bytes.
// ----------------------------------------------------------------------------
module hex_token_line_stats_test;

  // extra character codes
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FFEED = 8'h0C;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_UG    = 8'h47;

  localparam logic [hts_pkg::COUNT_BITS_DEF-1:0] COUNT_TOP = '1;
  localparam int BACK_END_CYCLES =
    2 + hts_pkg::VALUE_BITS_DEF + hts_pkg::COUNT_BITS_DEF + 9;
  localparam int SETTLE_CYCLES   = 3 * BACK_END_CYCLES;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int RANDOM_BYTES    = 1230;

  // line words typed into the table
  localparam hts_pkg::out_word_t NO_LINE    = '0;
  localparam hts_pkg::out_word_t EMPTY_LINE = '{1'b1, 16'd0, 32'd0, 39'd0};
  localparam hts_pkg::out_word_t PEAK_LINE  =
    '{1'b0, 16'd1, 32'hFFFF_FFFF, 39'd429496729500};
  localparam hts_pkg::out_word_t ZERO_LINE  = '{1'b0, 16'd1, 32'd0, 39'd0};

  // one table row: a byte sent reps times, with an optional typed line word
  typedef struct packed {
    logic [7:0]         ch;
    logic               eos;
    logic [7:0]         reps;
    logic               typed;
    hts_pkg::out_word_t want;
  } dir_row_t;

  localparam int NROWS = 27;
  localparam dir_row_t PLAN [0:NROWS-1] = '{
    '{hts_pkg::CH_LF,     1'b0, 8'd1, 1'b1, EMPTY_LINE}, // empty line just after reset
    '{hts_pkg::CH_UF,     1'b0, 8'd8, 1'b0, NO_LINE},    // largest value
    '{hts_pkg::CH_LF,     1'b0, 8'd1, 1'b1, PEAK_LINE},
    '{hts_pkg::CH_LA,     1'b0, 8'd1, 1'b0, NO_LINE},
    '{CH_UG,              1'b0, 8'd1, 1'b0, NO_LINE},    // breaks the word
    '{hts_pkg::CH_9,      1'b0, 8'd1, 1'b0, NO_LINE},    // digit after a bad byte
    '{8'hFF,              1'b0, 8'd1, 1'b0, NO_LINE},    // non-ASCII byte
    '{CH_VT,              1'b0, 8'd1, 1'b0, NO_LINE},
    '{8'h80,              1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_SPACE,  1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_LF,     1'b0, 8'd1, 1'b1, EMPTY_LINE}, // only bad words
    '{hts_pkg::CH_LF_HEX, 1'b0, 8'd1, 1'b0, NO_LINE},
    '{CH_FFEED,           1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_UA,     1'b0, 8'd2, 1'b0, NO_LINE},
    '{hts_pkg::CH_TAB,    1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_0,      1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_CR,     1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_9,      1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_SPACE,  1'b0, 8'd1, 1'b0, NO_LINE},
    '{CH_UG,              1'b0, 8'd1, 1'b0, NO_LINE},    // line ends on a bad word
    '{hts_pkg::CH_LF,     1'b1, 8'd1, 1'b0, NO_LINE},    // end of stream, byte ignored
    '{hts_pkg::CH_9,      1'b1, 8'd1, 1'b0, NO_LINE},    // end of stream, nothing pending
    '{CH_1,               1'b0, 8'd9, 1'b0, NO_LINE},    // value wraps
    '{hts_pkg::CH_LF,     1'b0, 8'd1, 1'b0, NO_LINE},
    '{hts_pkg::CH_0,      1'b0, 8'd1, 1'b0, NO_LINE},
    '{8'h00,              1'b1, 8'd1, 1'b1, ZERO_LINE},  // lone zero closed by end of stream
    '{hts_pkg::CH_LF,     1'b0, 8'd1, 1'b1, EMPTY_LINE}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               char_valid = 1'b0;
  logic               char_stall;
  hts_pkg::in_word_t  char_word = '0;
  logic               line_valid;
  logic               line_stall = 1'b0;
  hts_pkg::out_word_t line_word;

  hex_token_line_stats dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_word  (line_word)
  );

  // line predictor state
  logic [hts_pkg::VALUE_BITS_DEF-1:0] acc_value;
  bit                                 acc_ok;
  bit                                 acc_digits;
  logic [hts_pkg::COUNT_BITS_DEF-1:0] ln_count;
  logic [47:0]                        ln_sum;
  logic [hts_pkg::VALUE_BITS_DEF-1:0] ln_max;

  hts_pkg::out_word_t pending_lines [$];
  int                 mismatches = 0;
  int                 lines_seen = 0;
  int                 bytes_sent = 0;
  bit                 steady = 1'b0;
  bit                 hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == hts_pkg::CH_SPACE || (c >= hts_pkg::CH_TAB && c <= hts_pkg::CH_CR);
  endfunction

  // 0..15 for a hex digit, 16 otherwise
  function automatic int nibble_of(logic [7:0] c);
    if (c >= hts_pkg::CH_0 && c <= hts_pkg::CH_9) return int'(c - hts_pkg::CH_0);
    if (c >= hts_pkg::CH_LA && c <= hts_pkg::CH_LF_HEX)
      return int'(c - hts_pkg::CH_LA) + 10;
    if (c >= hts_pkg::CH_UA && c <= hts_pkg::CH_UF) return int'(c - hts_pkg::CH_UA) + 10;
    return 16;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 12);
  endfunction

  function automatic hts_pkg::in_word_t make_byte(logic [7:0] ch, logic eos);
    hts_pkg::in_word_t w;
    w.char_code = ch;
    w.end_of_stream = eos;
    return w;
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return hts_pkg::CH_0 + 8'(r);
    if (r < 16) return hts_pkg::CH_LA + 8'(r - 10);
    return hts_pkg::CH_UA + 8'(r - 16);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return hts_pkg::CH_TAB;
      1: return CH_VT;
      2: return CH_FFEED;
      3: return hts_pkg::CH_CR;
      default: return hts_pkg::CH_SPACE;
    endcase
  endfunction

  task automatic clear_word();
    acc_value = '0;
    acc_ok = 1'b1;
    acc_digits = 1'b0;
  endtask

  task automatic clear_line();
    ln_count = '0;
    ln_sum = '0;
    ln_max = '0;
  endtask

  // fold the pending word into the line; count and sum stop at saturation
  task automatic close_word();
    if (acc_digits && acc_ok) begin
      if (ln_count != COUNT_TOP) begin
        ln_count = ln_count + 1'b1;
        ln_sum = ln_sum + acc_value;
      end
      if (acc_value > ln_max) ln_max = acc_value;
    end
    clear_word();
  endtask

  // line word: count, max and average x100 rounded half up
  task automatic finish_line(output hts_pkg::out_word_t res);
    logic [63:0] n, q, rm, avg;
    n = 64'(ln_count);
    avg = '0;
    if (n != 0) begin
      q = 64'(ln_sum) / n;
      rm = 64'(ln_sum) % n;
      avg = q * 100 + (rm * 200 + n) / (2 * n);
    end
    res.no_numbers = (n == 0);
    res.number_count = ln_count;
    res.max_value = (n == 0) ? '0 : ln_max;
    res.average_x100 = avg[hts_pkg::AVG_OUT_W-1:0];
    clear_line();
  endtask

  task automatic scan_byte(input hts_pkg::in_word_t w, output bit emits,
                           output hts_pkg::out_word_t res);
    int d;
    emits = 1'b0;
    res = '0;
    if (w.end_of_stream) begin
      close_word();
      if (ln_count != 0) begin
        emits = 1'b1;
        finish_line(res);
      end else begin
        clear_line();
      end
    end else if (is_blank(w.char_code)) begin
      close_word();
      if (w.char_code == hts_pkg::CH_LF) begin
        emits = 1'b1;
        finish_line(res);
      end
    end else begin
      d = nibble_of(w.char_code);
      if (d < 16) begin
        if (acc_ok) begin
          acc_value = (acc_value << 4) | hts_pkg::VALUE_BITS_DEF'(d);
          acc_digits = 1'b1;
        end
      end else begin
        acc_ok = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("line word %0d: %s is %0h, want %0h", lines_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_line(hts_pkg::out_word_t got);
    hts_pkg::out_word_t want;
    lines_seen++;
    if (pending_lines.size() == 0) begin
      report_mismatch("unlooked-for word, count", 64'(got.number_count), 0);
    end else begin
      want = pending_lines.pop_front();
      if (got.no_numbers !== want.no_numbers)
        report_mismatch("no_numbers", 64'(got.no_numbers), 64'(want.no_numbers));
      if (got.number_count !== want.number_count)
        report_mismatch("number_count", 64'(got.number_count), 64'(want.number_count));
      if (got.max_value !== want.max_value)
        report_mismatch("max_value", 64'(got.max_value), 64'(want.max_value));
      if (got.average_x100 !== want.average_x100)
        report_mismatch("average_x100", 64'(got.average_x100), 64'(want.average_x100));
    end
  endtask

  // offer one byte, wait for it to be taken, then predict its line word
  task automatic send_byte(input hts_pkg::in_word_t w, input bit typed = 1'b0,
                           input hts_pkg::out_word_t want = '0);
    bit taken;
    bit emits;
    hts_pkg::out_word_t res;
    while (take_break()) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word <= w;
    do begin
      @(negedge clk);
      taken = !char_stall;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
    scan_byte(w, emits, res);
    if (emits) pending_lines.push_back(typed ? want : res);
  endtask

  // sender pauses until every line word is back
  task automatic wait_drained();
    char_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed hex words, a few bad bytes, closed by newline or end of stream
  task automatic send_random_line();
    int nwords, len, bad_at;
    nwords = $urandom_range(0, 5);
    for (int k = 0; k < nwords; k++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      bad_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : -1;
      for (int j = 0; j < len; j++) begin
        if (j == bad_at)
          send_byte(make_byte(8'($urandom_range(0, 255)), 1'b0));
        else
          send_byte(make_byte(pick_hex(), 1'b0));
      end
      repeat ($urandom_range(1, 2)) send_byte(make_byte(pick_blank(), 1'b0));
    end
    if ($urandom_range(0, 19) == 0)
      send_byte(make_byte(8'($urandom_range(0, 255)), 1'b1));
    else
      send_byte(make_byte(hts_pkg::CH_LF, 1'b0));
  endtask

  // line word receiver with random stalls and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (!rst && line_valid && !line_stall) check_line(line_word);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        line_stall <= 1'b1;
      end else begin
        line_stall <= take_break();
      end
    end
  end

  // watchdog on cycles with no word taken on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (rst || (char_valid && !char_stall) || (line_valid && !line_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int start;
    int pick;
    clear_word();
    clear_line();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NROWS; i++) begin
      repeat (PLAN[i].reps)
        send_byte(make_byte(PLAN[i].ch, PLAN[i].eos), PLAN[i].typed, PLAN[i].want);
    end
    wait_drained();

    // receiver holds off while short lines pile up in the queue
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_byte(make_byte(pick_hex(), 1'b0));
      send_byte(make_byte(hts_pkg::CH_LF, 1'b0));
    end
    wait_drained();

    // random text
    start = bytes_sent;
    while (bytes_sent < start + RANDOM_BYTES) begin
      steady = (bytes_sent >= start + 500) && (bytes_sent < start + 800);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6))
          send_byte(make_byte(8'($urandom_range(0, 255)), 1'b0));
      end else if (pick < 11) begin
        send_byte(make_byte(8'($urandom_range(0, 255)), 1'b1));
      end else begin
        send_random_line();
      end
    end
    steady = 1'b0;
    char_valid <= 1'b0;

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
